/* src/assert_macros.svh */
// Assertion macros shared by the buffered serial port RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSP_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSP_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsp: next-cycle check failed");

`endif

/* src/bsp_pkg.sv */
// Package for the buffered serial port: payload structs, codes and defaults.
// Used by every other file of the block but bsp_ram and the assertion macros; depends on nothing.
package bsp_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int TX_DEPTH_DEF       = 16;
    localparam int RX_DEPTH_DEF       = 32;
    localparam int CHARS_PER_TICK_DEF = 4;

    // Configuration port.
    localparam int          CFG_IDX_W      = 1;
    localparam int          CFG_DATA_W     = 16;
    localparam logic        CFG_ASYNC_MODE = 1'b0;
    localparam logic        CFG_COST_LIMIT = 1'b1;
    localparam logic [15:0] COST_LIMIT_RESET = 16'd50;

    // Input commands.
    localparam logic [2:0] CMD_CONTROL = 3'd0;
    localparam logic [2:0] CMD_STATUS  = 3'd1;
    localparam logic [2:0] CMD_TX_DATA = 3'd2;
    localparam logic [2:0] CMD_RX_READ = 3'd3;
    localparam logic [2:0] CMD_RX_BYTE = 3'd4;
    localparam logic [2:0] CMD_TICK    = 3'd5;

    // Codes written to the command register.
    localparam logic [7:0] CODE_IRQ_ON  = 8'd3;
    localparam logic [7:0] CODE_IRQ_OFF = 8'd4;

    // Result kinds.
    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    localparam logic [15:0] EMPTY_READ = 16'hFFFF;
    localparam logic [15:0] COST_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  value;
        logic [15:0] timeslice;
    } bsp_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] read_data;
        logic [7:0]  tx_char;
        logic        interrupt;
        logic        stall_hint;
        logic        last;
    } bsp_result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic run_single;
        logic start_drain;
        logic drain_step;
    } bsp_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic drain_needed;
        logic drain_last;
    } bsp_sts_t;

endpackage

/* src/bsp_item_if.sv */
// Input channel of the buffered serial port: valid, ready and one item.
// Depends on bsp_pkg for the item struct.
interface bsp_item_if;
    logic              valid;
    logic              ready;
    bsp_pkg::bsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/bsp_result_if.sv */
// Output channel of the buffered serial port: valid, ready and one result.
// Depends on bsp_pkg for the result struct.
interface bsp_result_if;
    logic                valid;
    logic                ready;
    bsp_pkg::bsp_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/bsp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module bsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bsp_datapath.sv */
// Datapath of the buffered serial port: registers, both buffers and the result register.
// Depends on bsp_pkg and bsp_ram; driven by bsp_ctrl through bsp_ctl_t.
module bsp_datapath #(
    parameter int TX_DEPTH       = bsp_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH       = bsp_pkg::RX_DEPTH_DEF,
    parameter int CHARS_PER_TICK = bsp_pkg::CHARS_PER_TICK_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  bsp_pkg::bsp_item_t             item_data,
    input  bsp_pkg::bsp_ctl_t              ctl,
    output bsp_pkg::bsp_sts_t              sts,
    output logic                           result_valid,
    input  logic                           result_ready,
    output bsp_pkg::bsp_result_t           result_data
);

    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_FW = $clog2(TX_DEPTH + 1);
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int CNT_W = $clog2(CHARS_PER_TICK + 1);

    localparam logic [TX_FW-1:0] TX_FULL     = TX_FW'(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST     = RX_AW'(RX_DEPTH - 1);
    localparam logic [RX_CW-1:0] RX_CREDIT_0 = RX_CW'(RX_DEPTH);
    localparam logic [15:0]      CPT         = 16'(CHARS_PER_TICK);
    localparam logic [CNT_W-1:0] CNT_ONE     = CNT_W'(1);

    // Configuration and port state.
    logic              async_reg, async_next;
    logic [15:0]       cost_limit_reg, cost_limit_next;
    logic              irq_en_reg, irq_en_next;
    logic              busy_reg, busy_next;
    logic [15:0]       cost_reg, cost_next;
    logic [TX_FW-1:0]  tx_fill_reg, tx_fill_next;
    logic [TX_FW-1:0]  tx_pos_reg, tx_pos_next;
    logic [RX_AW-1:0]  rx_wr_idx_reg, rx_wr_idx_next;
    logic              rx_wr_wrap_reg, rx_wr_wrap_next;
    logic [RX_AW-1:0]  rx_rd_idx_reg, rx_rd_idx_next;
    logic              rx_rd_wrap_reg, rx_rd_wrap_next;
    logic [RX_CW-1:0]  rx_credit_reg, rx_credit_next;
    logic [CNT_W-1:0]  drain_cnt_reg, drain_cnt_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers.
    bsp_pkg::bsp_item_t   item_reg;
    bsp_pkg::bsp_result_t out_data_reg, out_data_next;
    logic                 out_load;

    // Buffer ports.
    logic             tx_we, rx_we;
    logic [7:0]       tx_rd_data, rx_rd_data;
    logic [TX_FW-1:0] tx_pos_inc;

    // Drain count for a tick: pending characters, capped by budget and per-tick limit.
    logic [TX_FW-1:0] tx_pend;
    logic [15:0]      pend_wide, pend_by_ts, pend_capped;
    logic             rx_empty, direct_send;

    assign tx_pend     = tx_fill_reg - tx_pos_reg;
    assign pend_wide   = 16'(tx_pend);
    assign pend_by_ts  = (pend_wide > item_reg.timeslice) ? item_reg.timeslice : pend_wide;
    assign pend_capped = (pend_by_ts > CPT) ? CPT : pend_by_ts;
    assign rx_empty    = (rx_wr_idx_reg == rx_rd_idx_reg) && (rx_wr_wrap_reg == rx_rd_wrap_reg);
    assign direct_send = (!async_reg || (cost_reg < cost_limit_reg)) && (tx_fill_reg == '0);
    assign tx_pos_inc  = tx_pos_reg + TX_FW'(1);

    // Status toward the controller.
    assign sts.out_free     = !out_valid_reg || result_ready;
    assign sts.drain_needed = (item_reg.command == bsp_pkg::CMD_TICK) && (cost_reg == '0)
                              && (pend_capped != '0);
    assign sts.drain_last   = (drain_cnt_reg == CNT_ONE);

    // Next-state logic for all port state and the result register.
    always_comb
    begin
        async_next      = async_reg;
        cost_limit_next = cost_limit_reg;
        irq_en_next     = irq_en_reg;
        busy_next       = busy_reg;
        cost_next       = cost_reg;
        tx_fill_next    = tx_fill_reg;
        tx_pos_next     = tx_pos_reg;
        rx_wr_idx_next  = rx_wr_idx_reg;
        rx_wr_wrap_next = rx_wr_wrap_reg;
        rx_rd_idx_next  = rx_rd_idx_reg;
        rx_rd_wrap_next = rx_rd_wrap_reg;
        rx_credit_next  = rx_credit_reg;
        drain_cnt_next  = drain_cnt_reg;
        tx_we           = 1'b0;
        rx_we           = 1'b0;
        out_load        = 1'b0;
        out_data_next   = '0;

        // Configuration writes.
        if (cfg_wr_en)
        begin
            case (cfg_index)
                bsp_pkg::CFG_ASYNC_MODE: async_next      = cfg_wdata[0];
                bsp_pkg::CFG_COST_LIMIT: cost_limit_next = cfg_wdata;
                default: ;
            endcase
        end

        // Items that give a single result.
        if (ctl.run_single)
        begin
            out_load           = 1'b1;
            out_data_next.last = 1'b1;
            out_data_next.kind = bsp_pkg::KIND_NONE;
            case (item_reg.command)
                bsp_pkg::CMD_CONTROL:
                begin
                    out_data_next.kind = bsp_pkg::KIND_REPLY;
                    if (item_reg.value == bsp_pkg::CODE_IRQ_ON)
                    begin
                        irq_en_next = 1'b1;
                    end
                    else if (item_reg.value == bsp_pkg::CODE_IRQ_OFF)
                    begin
                        irq_en_next = 1'b0;
                    end
                end
                bsp_pkg::CMD_STATUS:
                begin
                    out_data_next.kind       = bsp_pkg::KIND_REPLY;
                    out_data_next.read_data  = 16'(busy_reg);
                    out_data_next.stall_hint = busy_reg;
                end
                bsp_pkg::CMD_TX_DATA:
                begin
                    if (direct_send)
                    begin
                        out_data_next.kind    = bsp_pkg::KIND_CHAR;
                        out_data_next.tx_char = item_reg.value;
                        if (cost_reg != bsp_pkg::COST_MAX)
                        begin
                            cost_next = cost_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        out_data_next.kind = bsp_pkg::KIND_REPLY;
                        if (tx_fill_reg < TX_FULL)
                        begin
                            tx_we        = 1'b1;
                            tx_fill_next = tx_fill_reg + TX_FW'(1);
                            if (tx_fill_next == TX_FULL)
                            begin
                                busy_next = 1'b1;
                            end
                        end
                    end
                end
                bsp_pkg::CMD_RX_READ:
                begin
                    out_data_next.kind = bsp_pkg::KIND_REPLY;
                    if (rx_empty)
                    begin
                        out_data_next.read_data  = bsp_pkg::EMPTY_READ;
                        out_data_next.stall_hint = 1'b1;
                    end
                    else
                    begin
                        out_data_next.read_data = 16'(rx_rd_data);
                        if (rx_rd_idx_reg == RX_LAST)
                        begin
                            rx_rd_idx_next  = '0;
                            rx_rd_wrap_next = !rx_rd_wrap_reg;
                        end
                        else
                        begin
                            rx_rd_idx_next = rx_rd_idx_reg + RX_AW'(1);
                        end
                        if (rx_credit_reg < RX_CREDIT_0)
                        begin
                            rx_credit_next = rx_credit_reg + RX_CW'(1);
                        end
                    end
                end
                bsp_pkg::CMD_RX_BYTE:
                begin
                    if (rx_credit_reg != '0)
                    begin
                        rx_we                   = 1'b1;
                        out_data_next.interrupt = irq_en_reg;
                        rx_credit_next          = rx_credit_reg - RX_CW'(1);
                        if (rx_wr_idx_reg == RX_LAST)
                        begin
                            rx_wr_idx_next  = '0;
                            rx_wr_wrap_next = !rx_wr_wrap_reg;
                        end
                        else
                        begin
                            rx_wr_idx_next = rx_wr_idx_reg + RX_AW'(1);
                        end
                    end
                end
                bsp_pkg::CMD_TICK:
                begin
                    // A tick that reaches here has cost to pay or nothing to send.
                    if (cost_reg != '0)
                    begin
                        cost_next = (cost_reg < item_reg.timeslice) ? '0
                                    : cost_reg - item_reg.timeslice;
                    end
                end
                default: ;
            endcase
        end

        // Load the number of characters this tick will drain.
        if (ctl.start_drain)
        begin
            drain_cnt_next = pend_capped[CNT_W-1:0];
        end

        // Send one buffered character; the one that empties the buffer resets it.
        if (ctl.drain_step)
        begin
            out_load              = 1'b1;
            out_data_next.kind    = bsp_pkg::KIND_CHAR;
            out_data_next.tx_char = tx_rd_data;
            out_data_next.last    = (drain_cnt_reg == CNT_ONE);
            drain_cnt_next        = drain_cnt_reg - CNT_ONE;
            if (tx_pos_inc == tx_fill_reg)
            begin
                tx_pos_next             = '0;
                tx_fill_next            = '0;
                busy_next               = 1'b0;
                out_data_next.interrupt = irq_en_reg;
            end
            else
            begin
                tx_pos_next = tx_pos_inc;
            end
        end

        // Result register handshake.
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            async_reg      <= 1'b0;
            cost_limit_reg <= bsp_pkg::COST_LIMIT_RESET;
            irq_en_reg     <= 1'b0;
            busy_reg       <= 1'b0;
            cost_reg       <= '0;
            tx_fill_reg    <= '0;
            tx_pos_reg     <= '0;
            rx_wr_idx_reg  <= '0;
            rx_wr_wrap_reg <= 1'b0;
            rx_rd_idx_reg  <= '0;
            rx_rd_wrap_reg <= 1'b0;
            rx_credit_reg  <= RX_CREDIT_0;
            drain_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            async_reg      <= async_next;
            cost_limit_reg <= cost_limit_next;
            irq_en_reg     <= irq_en_next;
            busy_reg       <= busy_next;
            cost_reg       <= cost_next;
            tx_fill_reg    <= tx_fill_next;
            tx_pos_reg     <= tx_pos_next;
            rx_wr_idx_reg  <= rx_wr_idx_next;
            rx_wr_wrap_reg <= rx_wr_wrap_next;
            rx_rd_idx_reg  <= rx_rd_idx_next;
            rx_rd_wrap_reg <= rx_rd_wrap_next;
            rx_credit_reg  <= rx_credit_next;
            drain_cnt_reg  <= drain_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: the accepted item and the pending result.
    always_ff @(posedge clk)
    begin
        if (ctl.take_item)
        begin
            item_reg <= item_data;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // The read ports follow the next pointer values, so the registered read data
    // matches the registered pointer.
    bsp_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_we),
        .wr_addr (tx_fill_reg[TX_AW-1:0]),
        .wr_data (item_reg.value),
        .rd_addr (tx_pos_next[TX_AW-1:0]),
        .rd_data (tx_rd_data)
    );

    bsp_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_we),
        .wr_addr (rx_wr_idx_reg),
        .wr_data (item_reg.value),
        .rd_addr (rx_rd_idx_next),
        .rd_data (rx_rd_data)
    );

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

/* src/bsp_ctrl.sv */
// Controller of the buffered serial port: accepts items and sequences the datapath.
// Depends on bsp_pkg for the command and status structs.
module bsp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  bsp_pkg::bsp_sts_t sts,
    output bsp_pkg::bsp_ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECIDE = 3'b010,
        S_DRAIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Sequencing: one item at a time, one result per cycle in a drain when there is room.
    always_comb
    begin
        state_next  = state_reg;
        item_ready  = 1'b0;
        ctl         = '0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready    = 1'b1;
                ctl.take_item = item_valid;
                if (item_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.drain_needed)
                begin
                    ctl.start_drain = 1'b1;
                    state_next      = S_DRAIN;
                end
                else if (sts.out_free)
                begin
                    ctl.run_single = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (sts.out_free)
                begin
                    ctl.drain_step = 1'b1;
                    if (sts.drain_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/buffered_serial_port_top.sv */
// Channel    Dir   Transfer
// item       sink  command, value, timeslice
// result     src   kind, read_data, tx_char, interrupt, stall_hint, last
// cfg        sink  cfg_wr_en, cfg_index, cfg_wdata (write only)
//
// Control, status, data and receive items pass from the item register through the
// decide state to the result register. A draining tick sends one character a cycle
// while there is room, paced by the single read port of the transmit buffer.
// The block is ready right after reset; there is no clearing pass.
// A stalled result holds its register and the controller waits for room.
`include "assert_macros.svh"

// Top level of the buffered serial port; depends on bsp_pkg, both channel
// interfaces, bsp_ctrl and bsp_datapath.
module buffered_serial_port_top #(
    parameter int TX_DEPTH       = bsp_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH       = bsp_pkg::RX_DEPTH_DEF,
    parameter int CHARS_PER_TICK = bsp_pkg::CHARS_PER_TICK_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    bsp_item_if.sink                       item,
    bsp_result_if.source                   result
);

    bsp_pkg::bsp_ctl_t ctl;
    bsp_pkg::bsp_sts_t sts;
    logic              item_ready;

    // Controller.
    bsp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    assign item.ready = item_ready;

    // Datapath.
    bsp_datapath #(
        .TX_DEPTH       (TX_DEPTH),
        .RX_DEPTH       (RX_DEPTH),
        .CHARS_PER_TICK (CHARS_PER_TICK)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item_data    (item.data),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .result_data  (result.data)
    );

    // Checks on the sequencing between controller and datapath.
    `BSP_CHECK_NEXT(a_one_item_at_a_time, item.valid && item.ready, !item.ready)
    `BSP_CHECK_NOW(a_emit_needs_room, ctl.run_single || ctl.drain_step, sts.out_free)
    `BSP_CHECK_NEXT(a_emit_loads_result, ctl.run_single || ctl.drain_step, result.valid)

endmodule
